@@ design/skl_pkg.sv @@
package skl_pkg;

  localparam int KEY_W    = 32;
  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_DELETE = 2'd1,
    FUNC_LIST   = 2'd2
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_INSERTED  = 3'd0,
    STATUS_FULL      = 3'd1,
    STATUS_REMOVED   = 3'd2,
    STATUS_NOT_FOUND = 3'd3,
    STATUS_LISTED    = 3'd4,
    STATUS_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_DELETE,
    CMD_ROTATE
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_LIST
  } state_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic signed [KEY_W-1:0] key;
  } cell_ctrl_t;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic                    ge;
    logic                    eq;
  } cell_out_t;

  localparam cell_out_t CELL_NONE = '{valid: 1'b0, key: '0, ge: 1'b0, eq: 1'b0};

endpackage

@@ design/skl_if.sv @@
interface skl_req_if;
  logic                              valid;
  logic                              ready;
  logic [skl_pkg::FUNC_W-1:0]        func;
  logic signed [skl_pkg::KEY_W-1:0]  key;

  modport source(output valid, output func, output key, input ready);
  modport sink(input valid, input func, input key, output ready);
endinterface

interface skl_res_if;
  logic                              valid;
  logic                              ready;
  logic [skl_pkg::STATUS_W-1:0]      status;
  logic signed [skl_pkg::KEY_W-1:0]  key_out;
  logic                              last;

  modport source(output valid, output status, output key_out, output last, input ready);
  modport sink(input valid, input status, input key_out, input last, output ready);
endinterface

@@ design/skl_cell.sv @@
module skl_cell (
  input  logic                clk,
  input  logic                rst,
  input  skl_pkg::cell_ctrl_t ctrl,
  input  skl_pkg::cell_out_t  left,
  input  skl_pkg::cell_out_t  right,
  input  logic signed [skl_pkg::KEY_W-1:0] head_key,
  input  logic                found,
  output skl_pkg::cell_out_t  self
);

  logic                             valid;
  logic signed [skl_pkg::KEY_W-1:0] key;
  logic                             valid_next;
  logic signed [skl_pkg::KEY_W-1:0] key_next;
  logic                             ge;

  // A cell is at or past the request position when it is empty or its key is not smaller.
  assign ge = !valid || (key >= ctrl.key);

  assign self.valid = valid;
  assign self.key   = key;
  assign self.ge    = ge;
  assign self.eq    = valid && (key == ctrl.key);

  always_comb begin
    valid_next = valid;
    key_next   = key;
    case (ctrl.cmd)
      skl_pkg::CMD_INSERT: begin
        if (ge && left.ge) begin
          valid_next = left.valid;
          key_next   = left.key;
        end else if (ge) begin
          valid_next = 1'b1;
          key_next   = ctrl.key;
        end
      end
      skl_pkg::CMD_DELETE: begin
        if (ge && found) begin
          valid_next = right.valid;
          key_next   = right.key;
        end
      end
      skl_pkg::CMD_ROTATE: begin
        if (right.valid) begin
          key_next = right.key;
        end else if (valid) begin
          key_next = head_key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    key <= key_next;
  end

endmodule

@@ design/sorted_key_list.sv @@
// Channel  Direction  Payload
// req      in         func, key
// res      out        status, key_out, last
//
// Insert, delete and an unused code may follow back to back while results are taken.
// During a readout of the stored keys, the head cell feeds the output register one key
// per cycle while results are taken, as the chain rotates back into order.
// A readout of an empty store returns a single empty result.
// Reset empties the store at once; a stalled result holds the block until taken.
module sorted_key_list #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  skl_req_if.sink     req,
  skl_res_if.source   res
);

  localparam int CW = $clog2(CAPACITY + 1);

  skl_pkg::cell_out_t  cells [CAPACITY];
  skl_pkg::cell_ctrl_t ctrl;
  logic [CAPACITY-1:0] eq_vec;
  logic                found;
  logic                full;

  skl_pkg::state_t     state;
  skl_pkg::state_t     state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       remaining;

  logic                                out_valid;
  logic [skl_pkg::STATUS_W-1:0]        out_status;
  logic signed [skl_pkg::KEY_W-1:0]    out_key;
  logic                                out_last;

  logic slot_free;
  logic ready;
  logic take;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      skl_pkg::cell_out_t left_in;
      skl_pkg::cell_out_t right_in;
      if (g == 0) begin : g_first
        assign left_in = skl_pkg::CELL_NONE;
      end else begin : g_mid_l
        assign left_in = cells[g-1];
      end
      if (g == CAPACITY - 1) begin : g_last
        assign right_in = skl_pkg::CELL_NONE;
      end else begin : g_mid_r
        assign right_in = cells[g+1];
      end
      skl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .ctrl     (ctrl),
        .left     (left_in),
        .right    (right_in),
        .head_key (cells[0].key),
        .found    (found),
        .self     (cells[g])
      );
      assign eq_vec[g] = cells[g].eq;
    end
  endgenerate

  assign found     = |eq_vec;
  assign full      = cells[CAPACITY-1].valid;
  assign slot_free = !out_valid || res.ready;
  assign take      = req.valid && ready;

  assign req.ready   = ready;
  assign res.valid   = out_valid;
  assign res.status  = out_status;
  assign res.key_out = out_key;
  assign res.last    = out_last;

  always_comb begin
    state_next = state;
    case (state)
      skl_pkg::ST_IDLE: begin
        if (take && (req.func == skl_pkg::FUNC_LIST) && (count != '0)) begin
          state_next = skl_pkg::ST_LIST;
        end
      end
      skl_pkg::ST_LIST: begin
        if (slot_free && (remaining == CW'(1))) begin
          state_next = skl_pkg::ST_IDLE;
        end
      end
      default: state_next = skl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ready    = 1'b0;
    ctrl.cmd = skl_pkg::CMD_HOLD;
    ctrl.key = req.key;
    case (state)
      skl_pkg::ST_IDLE: begin
        ready = slot_free;
        if (req.valid && slot_free) begin
          if ((req.func == skl_pkg::FUNC_INSERT) && !full) begin
            ctrl.cmd = skl_pkg::CMD_INSERT;
          end else if ((req.func == skl_pkg::FUNC_DELETE) && found) begin
            ctrl.cmd = skl_pkg::CMD_DELETE;
          end
        end
      end
      skl_pkg::ST_LIST: begin
        if (slot_free) begin
          ctrl.cmd = skl_pkg::CMD_ROTATE;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skl_pkg::ST_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctrl.cmd == skl_pkg::CMD_INSERT) begin
        count <= count + CW'(1);
      end else if (ctrl.cmd == skl_pkg::CMD_DELETE) begin
        count <= count - CW'(1);
      end

      if (take) begin
        case (req.func)
          skl_pkg::FUNC_INSERT: begin
            out_valid  <= 1'b1;
            out_status <= full ? skl_pkg::STATUS_FULL : skl_pkg::STATUS_INSERTED;
            out_key    <= req.key;
            out_last   <= 1'b1;
          end
          skl_pkg::FUNC_DELETE: begin
            out_valid  <= 1'b1;
            out_status <= found ? skl_pkg::STATUS_REMOVED : skl_pkg::STATUS_NOT_FOUND;
            out_key    <= req.key;
            out_last   <= 1'b1;
          end
          skl_pkg::FUNC_LIST: begin
            if (count == '0) begin
              out_valid  <= 1'b1;
              out_status <= skl_pkg::STATUS_EMPTY;
              out_key    <= '0;
              out_last   <= 1'b1;
            end else begin
              out_valid  <= 1'b0;
            end
            remaining <= count;
          end
          default: begin
            out_valid <= 1'b0;
          end
        endcase
      end else if ((state == skl_pkg::ST_LIST) && slot_free) begin
        out_valid  <= 1'b1;
        out_status <= skl_pkg::STATUS_LISTED;
        out_key    <= cells[0].key;
        out_last   <= (remaining == CW'(1));
        remaining  <= remaining - CW'(1);
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ verif/sorted_key_list_tb.sv @@
`timescale 1ns / 1ps

module sorted_key_list_tb;

  localparam int CAPACITY = 32;
  localparam logic [skl_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int TAIL_ITEMS = 60;
  localparam int HOLD_AFTER = 120;
  localparam int HOLD_CYCLES = 250;

  typedef struct packed {
    logic [skl_pkg::FUNC_W-1:0]       func;
    logic signed [skl_pkg::KEY_W-1:0] key;
  } request_t;

  typedef struct {
    skl_pkg::status_t                 status;
    logic signed [skl_pkg::KEY_W-1:0] key;
    logic                             last;
  } reply_t;

  logic clk;
  logic rst;

  skl_req_if req_ch();
  skl_res_if res_ch();

  sorted_key_list #(.CAPACITY(CAPACITY)) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .res(res_ch)
  );

  request_t                         request_backlog[$];
  reply_t                           due_replies[$];
  logic signed [skl_pkg::KEY_W-1:0] shadow_keys[$];
  logic signed [skl_pkg::KEY_W-1:0] key_pool[16];
  int                               mismatches = 0;
  int                               cycle_count = 0;
  int                               send_gap = 0;
  int                               take_gap = 0;
  int                               hold_left = 0;
  bit                               hold_done = 0;
  int                               results_taken = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.func = skl_pkg::FUNC_INSERT;
    req_ch.key = '0;
    res_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_mismatch(string msg);
    if (mismatches < 100) $display("mismatch: %s", msg);
    mismatches++;
  endtask

  task automatic add_request(logic [skl_pkg::FUNC_W-1:0] func,
                             logic signed [skl_pkg::KEY_W-1:0] key);
    request_t r;
    r.func = func;
    r.key = key;
    request_backlog.push_back(r);
  endtask

  function automatic logic signed [skl_pkg::KEY_W-1:0] pick_key();
    if ($urandom_range(0, 9) < 6) return key_pool[$urandom_range(0, 15)];
    return $urandom;
  endfunction

  // Keeps the ascending list in step with the block and queues the replies
  // that each accepted request is owed.
  task automatic track_key_list(request_t r);
    int pos;
    pos = 0;
    case (r.func)
      skl_pkg::FUNC_INSERT: begin
        if (shadow_keys.size() >= CAPACITY) begin
          due_replies.push_back(reply_t'{skl_pkg::STATUS_FULL, r.key, 1'b1});
        end else begin
          while (pos < shadow_keys.size() && shadow_keys[pos] < r.key) pos++;
          shadow_keys.insert(pos, r.key);
          due_replies.push_back(reply_t'{skl_pkg::STATUS_INSERTED, r.key, 1'b1});
        end
      end
      skl_pkg::FUNC_DELETE: begin
        while (pos < shadow_keys.size() && shadow_keys[pos] != r.key) pos++;
        if (pos == shadow_keys.size()) begin
          due_replies.push_back(reply_t'{skl_pkg::STATUS_NOT_FOUND, r.key, 1'b1});
        end else begin
          shadow_keys.delete(pos);
          due_replies.push_back(reply_t'{skl_pkg::STATUS_REMOVED, r.key, 1'b1});
        end
      end
      skl_pkg::FUNC_LIST: begin
        if (shadow_keys.size() == 0) begin
          due_replies.push_back(reply_t'{skl_pkg::STATUS_EMPTY, '0, 1'b1});
        end else begin
          foreach (shadow_keys[i]) begin
            due_replies.push_back(reply_t'{skl_pkg::STATUS_LISTED, shadow_keys[i],
                                           i == shadow_keys.size() - 1});
          end
        end
      end
      default: ;
    endcase
  endtask

  function automatic bit idling_allowed(int period);
    return request_backlog.size() > TAIL_ITEMS && ((cycle_count / period) % 3 != 2);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.func <= skl_pkg::FUNC_INSERT;
      req_ch.key <= '0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) track_key_list(request_backlog.pop_front());
      if (!(req_ch.valid && !req_ch.ready)) begin
        if (send_gap > 0) begin
          send_gap--;
          req_ch.valid <= 1'b0;
        end else if (request_backlog.size() == 0) begin
          req_ch.valid <= 1'b0;
        end else if (idling_allowed(150) && $urandom_range(0, 4) == 0) begin
          send_gap = $urandom_range(0, 7);
          req_ch.valid <= 1'b0;
        end else begin
          req_ch.valid <= 1'b1;
          req_ch.func <= request_backlog[0].func;
          req_ch.key <= request_backlog[0].key;
        end
      end
    end
  end

  // The receiver stalls in short bursts, and once for a long stretch so that
  // the block backs up and refuses further requests.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else if (!hold_done && results_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        res_ch.ready <= 1'b0;
      end else if (take_gap > 0) begin
        take_gap--;
        res_ch.ready <= 1'b0;
      end else if (idling_allowed(170) && $urandom_range(0, 4) == 0) begin
        take_gap = $urandom_range(0, 7);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    reply_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (due_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d key %0d last %0b",
                                  res_ch.status, res_ch.key_out, res_ch.last));
      end else begin
        want = due_replies.pop_front();
        if (res_ch.status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", res_ch.status, want.status));
        if (res_ch.key_out !== want.key)
          report_mismatch($sformatf("key_out %0d, expected %0d", res_ch.key_out, want.key));
        if (res_ch.last !== want.last)
          report_mismatch($sformatf("last %0b, expected %0b", res_ch.last, want.last));
      end
    end
  end

  initial begin
    int pick;
    bit filling;

    key_pool[0] = 32'sh7fffffff;
    key_pool[1] = 32'sh80000000;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    key_pool[4] = 32'sd1;
    for (int i = 5; i < 16; i++)
      key_pool[i] = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 40);

    add_request(skl_pkg::FUNC_INSERT, 32'sh7fffffff);
    add_request(skl_pkg::FUNC_INSERT, 32'sh80000000);
    add_request(skl_pkg::FUNC_INSERT, '0);
    add_request(skl_pkg::FUNC_INSERT, -32'sd1);
    add_request(skl_pkg::FUNC_INSERT, '0);
    add_request(skl_pkg::FUNC_INSERT, 32'sd1);
    add_request(skl_pkg::FUNC_LIST, $urandom);
    add_request(skl_pkg::FUNC_DELETE, '0);
    add_request(skl_pkg::FUNC_DELETE, 32'sd12345);
    add_request(skl_pkg::FUNC_LIST, $urandom);
    add_request(FUNC_UNUSED, 32'sd5);
    add_request(skl_pkg::FUNC_INSERT, 32'sh7fffffff);
    add_request(skl_pkg::FUNC_DELETE, 32'sh7fffffff);
    add_request(skl_pkg::FUNC_DELETE, 32'sh80000000);
    add_request(skl_pkg::FUNC_DELETE, '0);
    add_request(skl_pkg::FUNC_DELETE, -32'sd1);
    add_request(skl_pkg::FUNC_DELETE, 32'sd1);
    add_request(skl_pkg::FUNC_DELETE, 32'sh7fffffff);
    add_request(skl_pkg::FUNC_LIST, $urandom);
    add_request(skl_pkg::FUNC_DELETE, '0);
    add_request(FUNC_UNUSED, 32'sh80000000);

    for (int n = 0; n < CAPACITY + 4; n++) add_request(skl_pkg::FUNC_INSERT, pick_key());
    add_request(skl_pkg::FUNC_LIST, $urandom);

    for (int seg = 0; seg < 10; seg++) begin
      filling = (seg % 2 == 0);
      for (int n = 0; n < 42; n++) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) add_request(FUNC_UNUSED, $urandom);
        else if (pick < 13) add_request(skl_pkg::FUNC_LIST, $urandom);
        else if (pick < (filling ? 68 : 33)) add_request(skl_pkg::FUNC_INSERT, pick_key());
        else add_request(skl_pkg::FUNC_DELETE, pick_key());
      end
    end

    @(negedge rst);
    while (request_backlog.size() != 0 || req_ch.valid || due_replies.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule
